FILE: src/rmp_pkg.sv
// Shared types and constants for the bilinear remap block.
// Field widths, the queue entry layout and the front/back status word.
// No dependencies.
`default_nettype none

package rmp_pkg;

	localparam int IDX_W   = 19;
	localparam int PIX_W   = 8;
	localparam int WGT_W   = 16;
	localparam int PROD_W  = WGT_W + PIX_W;
	localparam int ACC_W   = PROD_W + 3;

	localparam int NUM_TAPS = 4;
	localparam int STEP_W   = $clog2(NUM_TAPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TAPS - 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

	typedef struct packed {
		logic                               is_map;
		logic [IDX_W-1:0]                   load_addr;
		logic [PIX_W-1:0]                   load_pixel;
		logic                               load_ok;
		logic [NUM_TAPS-1:0][IDX_W-1:0]     src;
		logic [NUM_TAPS-1:0]                src_ok;
		logic [NUM_TAPS-1:0][WGT_W-1:0]     wgt;
		logic [IDX_W-1:0]                   dest;
	} rmp_entry_t;

	typedef struct packed {
		logic       valid;
		rmp_entry_t entry;
	} rmp_head_t;

	typedef struct packed {
		logic              pop;
		logic [STEP_W-1:0] step;
	} rmp_back_stat_t;

endpackage

`default_nettype wire

FILE: src/bilinear_map_remap_top.sv
// Bilinear remap block: a load word writes one 8-bit pixel into the source
// store; a map word reads four source pixels, weights them with four unsigned
// fixed-point weights, rounds, shifts and saturates, and returns one result
// word (out_index, out_pixel). Load words return nothing.
// Both channels use valid/stall; a word moves at a clock edge with valid high
// and stall low. req_stall rises when the four-entry request queue is full.
// Load words are taken and the four taps of each map word read one per cycle,
// unless a result is held by res_stall; taps are read through the single port
// of the source store, and a map word's taps may start while the previous
// word is still in the pipeline (tap read s1, product s2, result register).
// While a result is held by res_stall the tap pipeline holds too; the queue
// keeps taking words until full.
// Reset clears the queue, the tap sequencer and all valid flags; the source
// store is not cleared, and a tap that reads a never-written pixel gives an
// undefined result. A load beyond the store is dropped; a tap beyond it reads 0.
// Depends on rmp_pkg, rmp_front and rmp_back.
`default_nettype none

module bilinear_map_remap_top import rmp_pkg::*; #(
	parameter int IMAGE_PIXELS     = 524288,
	parameter int WEIGHT_FRAC_BITS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic                req_type,
	input  wire logic [IDX_W-1:0]    load_addr,
	input  wire logic [PIX_W-1:0]    load_pixel,
	input  wire logic [IDX_W-1:0]    src_index_a,
	input  wire logic [IDX_W-1:0]    src_index_b,
	input  wire logic [IDX_W-1:0]    src_index_c,
	input  wire logic [IDX_W-1:0]    src_index_d,
	input  wire logic [WGT_W-1:0]    weight_a,
	input  wire logic [WGT_W-1:0]    weight_b,
	input  wire logic [WGT_W-1:0]    weight_c,
	input  wire logic [WGT_W-1:0]    weight_d,
	input  wire logic [IDX_W-1:0]    dest_index,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic [IDX_W-1:0]         out_index,
	output logic [PIX_W-1:0]         out_pixel
);

	rmp_head_t       head;
	rmp_back_stat_t  stat;

	rmp_front #(
		.IMAGE_PIXELS (IMAGE_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.load_addr   (load_addr),
		.load_pixel  (load_pixel),
		.src_index_a (src_index_a),
		.src_index_b (src_index_b),
		.src_index_c (src_index_c),
		.src_index_d (src_index_d),
		.weight_a    (weight_a),
		.weight_b    (weight_b),
		.weight_c    (weight_c),
		.weight_d    (weight_d),
		.dest_index  (dest_index),
		.stat        (stat),
		.head        (head)
	);

	rmp_back #(
		.IMAGE_PIXELS     (IMAGE_PIXELS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_index (out_index),
		.out_pixel (out_pixel)
	);

`ifndef ASSERT_OFF
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> head.valid)
		else $error("queue popped while empty");

	a_map_pop_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.pop && head.entry.is_map) |-> (stat.step == LAST_STEP))
		else $error("map word retired before its last tap");

	a_stall_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> !stat.pop)
		else $error("queue advanced while result held");

	a_stall_holds_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> $stable(stat.step))
		else $error("tap sequencer moved while result held");
`endif

endmodule

`default_nettype wire

FILE: src/rmp_front.sv
// Front part of the remap block: accepts request words, classifies them
// (load or map, address range checks) and holds them in a short queue.
// Depends on rmp_pkg.
`default_nettype none

module rmp_front import rmp_pkg::*; #(
	parameter int IMAGE_PIXELS = 524288
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic                   req_type,
	input  wire logic [IDX_W-1:0]       load_addr,
	input  wire logic [PIX_W-1:0]       load_pixel,
	input  wire logic [IDX_W-1:0]       src_index_a,
	input  wire logic [IDX_W-1:0]       src_index_b,
	input  wire logic [IDX_W-1:0]       src_index_c,
	input  wire logic [IDX_W-1:0]       src_index_d,
	input  wire logic [WGT_W-1:0]       weight_a,
	input  wire logic [WGT_W-1:0]       weight_b,
	input  wire logic [WGT_W-1:0]       weight_c,
	input  wire logic [WGT_W-1:0]       weight_d,
	input  wire logic [IDX_W-1:0]       dest_index,
	input  wire rmp_back_stat_t         stat,
	output rmp_head_t                   head
);

	localparam int LIM_W = $clog2(IMAGE_PIXELS) + 1;
	localparam int CMP_W = (LIM_W > IDX_W) ? LIM_W : IDX_W;
	localparam logic [CMP_W-1:0] LIMIT = CMP_W'(IMAGE_PIXELS);

	rmp_entry_t              queue_q [QUEUE_DEPTH];
	rmp_entry_t              entry;
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    push;
	logic                    pop;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return CMP_W'(idx) < LIMIT;
	endfunction

	always_comb begin
		entry            = '0;
		entry.is_map     = req_type;
		entry.load_addr  = load_addr;
		entry.load_pixel = load_pixel;
		entry.load_ok    = in_range(load_addr);
		entry.src[0]     = src_index_a;
		entry.src[1]     = src_index_b;
		entry.src[2]     = src_index_c;
		entry.src[3]     = src_index_d;
		entry.src_ok[0]  = in_range(src_index_a);
		entry.src_ok[1]  = in_range(src_index_b);
		entry.src_ok[2]  = in_range(src_index_c);
		entry.src_ok[3]  = in_range(src_index_d);
		entry.wgt[0]     = weight_a;
		entry.wgt[1]     = weight_b;
		entry.wgt[2]     = weight_c;
		entry.wgt[3]     = weight_d;
		entry.dest       = dest_index;
	end

	assign req_stall  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = req_valid && !req_stall;
	assign pop        = stat.pop;
	assign head.valid = (count_q != '0);
	assign head.entry = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/rmp_back.sv
// Back part of the remap block: source pixel store, tap sequencer,
// multiply/accumulate pipeline, rounding, saturation and result register.
// Depends on rmp_pkg.
`default_nettype none

module rmp_back import rmp_pkg::*; #(
	parameter int IMAGE_PIXELS     = 524288,
	parameter int WEIGHT_FRAC_BITS = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rmp_head_t        head,
	output rmp_back_stat_t        stat,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic [IDX_W-1:0]      out_index,
	output logic [PIX_W-1:0]      out_pixel
);

	localparam int ADDR_W = $clog2(IMAGE_PIXELS);
	localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);

	logic [PIX_W-1:0]   mem [IMAGE_PIXELS];

	logic               adv;
	logic               issue_map;
	logic               issue_load;
	logic [STEP_W-1:0]  step_q;
	logic [EXT_W-1:0]   rd_ext;
	logic [EXT_W-1:0]   wr_ext;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;

	logic               vld_s1;
	logic               first_s1;
	logic               last_s1;
	logic               ok_s1;
	logic [WGT_W-1:0]   wgt_s1;
	logic [PIX_W-1:0]   rd_s1;
	logic [IDX_W-1:0]   dest_s1;

	logic               vld_s2;
	logic               first_s2;
	logic               last_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [IDX_W-1:0]   dest_s2;

	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   acc_sum;
	logic [ACC_W-1:0]   scaled;
	logic [PIX_W-1:0]   sat_pix;

	logic               res_valid_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [PIX_W-1:0]   out_pixel_q;

	// hold every stage while a finished result waits
	assign adv        = !(res_valid_q && res_stall);
	assign issue_map  = adv && head.valid && head.entry.is_map;
	assign issue_load = adv && head.valid && !head.entry.is_map;

	assign rd_ext  = EXT_W'(head.entry.src[step_q]);
	assign wr_ext  = EXT_W'(head.entry.load_addr);
	assign rd_addr = rd_ext[ADDR_W-1:0];
	assign wr_addr = wr_ext[ADDR_W-1:0];

	assign stat.pop  = issue_load || (issue_map && (step_q == LAST_STEP));
	assign stat.step = step_q;

	always_ff @(posedge clk) begin
		if (issue_load && head.entry.load_ok) begin
			mem[wr_addr] <= head.entry.load_pixel;
		end
		if (issue_map && head.entry.src_ok[step_q]) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (issue_map) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
			end
			if (adv) begin
				vld_s1      <= issue_map;
				vld_s2      <= vld_s1;
				res_valid_q <= vld_s2 && last_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_map) begin
			first_s1 <= (step_q == '0);
			last_s1  <= (step_q == LAST_STEP);
			ok_s1    <= head.entry.src_ok[step_q];
			wgt_s1   <= head.entry.wgt[step_q];
			dest_s1  <= head.entry.dest;
		end
		if (adv && vld_s1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			prod_s2  <= wgt_s1 * (ok_s1 ? rd_s1 : '0);
			dest_s2  <= dest_s1;
		end
	end

	always_comb begin
		acc_sum = (first_s2 ? ROUND : acc_q) + ACC_W'(prod_s2);
		scaled  = acc_sum >> WEIGHT_FRAC_BITS;
		sat_pix = (scaled > ACC_W'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2) begin
			acc_q <= acc_sum;
			if (last_s2) begin
				out_index_q <= dest_s2;
				out_pixel_q <= sat_pix;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_index = out_index_q;
	assign out_pixel = out_pixel_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for bilinear_map_remap_top: table-driven corner words, then random
// pixel loads and bilinear map entries, each checked against a table value or predictor.
// Depends on rmp_pkg and bilinear_map_remap_top.
`default_nettype none

module tb_top import rmp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IMG_PIXELS   = 524288;
	localparam int FRAC_BITS    = 15;
	localparam int RANDOM_WORDS = 1880;
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_MAP    = 1'b1;
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
	localparam logic [WGT_W-1:0] W_ONE   = WGT_W'(1 << FRAC_BITS);
	localparam logic [WGT_W-1:0] W_FULL  = {WGT_W{1'b1}};

	typedef struct packed {
		logic                           kind;
		logic [IDX_W-1:0]               addr;
		logic [PIX_W-1:0]               pix;
		logic [NUM_TAPS-1:0][IDX_W-1:0] src;
		logic [NUM_TAPS-1:0][WGT_W-1:0] wgt;
		logic [IDX_W-1:0]               dest;
		logic                           typed;
		logic [PIX_W-1:0]               typed_pixel;
	} remap_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [PIX_W-1:0] pixel;
	} remap_result_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	logic             req_type;
	logic [IDX_W-1:0] load_addr;
	logic [PIX_W-1:0] load_pixel;
	logic [IDX_W-1:0] src_index_a;
	logic [IDX_W-1:0] src_index_b;
	logic [IDX_W-1:0] src_index_c;
	logic [IDX_W-1:0] src_index_d;
	logic [WGT_W-1:0] weight_a;
	logic [WGT_W-1:0] weight_b;
	logic [WGT_W-1:0] weight_c;
	logic [WGT_W-1:0] weight_d;
	logic [IDX_W-1:0] dest_index;
	logic             res_valid;
	logic             res_stall;
	logic [IDX_W-1:0] out_index;
	logic [PIX_W-1:0] out_pixel;

	logic [PIX_W-1:0] image_copy [int];
	int unsigned      written_addrs [$];
	remap_result_t    pending_pixels [$];
	remap_word_t      directed_rows [$];

	int n_loads;
	int n_maps;
	int n_checked;
	int n_errors;
	int burst_left;

	bilinear_map_remap_top #(
		.IMAGE_PIXELS     (IMG_PIXELS),
		.WEIGHT_FRAC_BITS (FRAC_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.load_addr   (load_addr),
		.load_pixel  (load_pixel),
		.src_index_a (src_index_a),
		.src_index_b (src_index_b),
		.src_index_c (src_index_c),
		.src_index_d (src_index_d),
		.weight_a    (weight_a),
		.weight_b    (weight_b),
		.weight_c    (weight_c),
		.weight_d    (weight_d),
		.dest_index  (dest_index),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_index   (out_index),
		.out_pixel   (out_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_errors++;
	endtask

	function automatic logic [PIX_W-1:0] pixel_at(input logic [IDX_W-1:0] idx);
		if (int'(idx) >= IMG_PIXELS || !image_copy.exists(int'(idx)))
			return '0;
		return image_copy[int'(idx)];
	endfunction

	function automatic logic [PIX_W-1:0] bilinear_pixel(input remap_word_t w);
		logic [63:0] acc;
		acc = 64'(1) << (FRAC_BITS - 1);
		for (int k = 0; k < NUM_TAPS; k++)
			acc += 64'(w.wgt[k]) * 64'(pixel_at(w.src[k]));
		acc = acc >> FRAC_BITS;
		return (acc > 64'(PIX_MAX)) ? PIX_MAX : acc[PIX_W-1:0];
	endfunction

	function automatic remap_word_t load_word(input logic [IDX_W-1:0] addr,
			input logic [PIX_W-1:0] pix);
		remap_word_t w;
		w = '0;
		w.kind = REQ_LOAD;
		w.addr = addr;
		w.pix  = pix;
		w.src  = {NUM_TAPS{IDX_W'($urandom)}};
		w.dest = IDX_W'($urandom);
		return w;
	endfunction

	function automatic remap_word_t map_word(
			input logic [IDX_W-1:0] ia, input logic [IDX_W-1:0] ib,
			input logic [IDX_W-1:0] ic, input logic [IDX_W-1:0] id,
			input logic [WGT_W-1:0] wa, input logic [WGT_W-1:0] wb,
			input logic [WGT_W-1:0] wc, input logic [WGT_W-1:0] wd,
			input logic [IDX_W-1:0] dest, input logic typed,
			input logic [PIX_W-1:0] typed_pixel);
		remap_word_t w;
		w = '0;
		w.kind        = REQ_MAP;
		w.addr        = IDX_W'($urandom);
		w.pix         = PIX_W'($urandom);
		w.src         = {id, ic, ib, ia};
		w.wgt         = {wd, wc, wb, wa};
		w.dest        = dest;
		w.typed       = typed;
		w.typed_pixel = typed_pixel;
		return w;
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return W_ONE;
			2: return WGT_W'($urandom_range(0, 65535));
			default: return WGT_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_written();
		return IDX_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
	endfunction

	// call at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input remap_word_t w);
		remap_result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_type    = w.kind;
		load_addr   = w.addr;
		load_pixel  = w.pix;
		src_index_a = w.src[0];
		src_index_b = w.src[1];
		src_index_c = w.src[2];
		src_index_d = w.src[3];
		weight_a    = w.wgt[0];
		weight_b    = w.wgt[1];
		weight_c    = w.wgt[2];
		weight_d    = w.wgt[3];
		dest_index  = w.dest;
		req_valid   = 1'b1;
		do @(posedge clk); while (req_stall);
		if (w.kind == REQ_LOAD) begin
			n_loads++;
			if (int'(w.addr) < IMG_PIXELS) begin
				if (!image_copy.exists(int'(w.addr)))
					written_addrs.push_back(32'(w.addr));
				image_copy[int'(w.addr)] = w.pix;
			end
		end else begin
			n_maps++;
			r.index = w.dest;
			r.pixel = w.typed ? w.typed_pixel : bilinear_pixel(w);
			pending_pixels.push_back(r);
		end
		@(negedge clk);
	endtask

	// receiver: runs of stall or no stall, density set per stretch
	initial begin
		int mode;
		int run;
		logic hold;
		res_stall = 1'b0;
		mode = 0;
		forever begin
			if ($urandom_range(0, 15) == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: hold = 1'b0;
				1: hold = ($urandom_range(0, 3) == 0);
				2: hold = ($urandom_range(0, 3) != 0);
				default: hold = 1'($urandom_range(0, 1));
			endcase
			run = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(1, 4);
			repeat (run) begin
				@(negedge clk);
				res_stall = hold;
			end
		end
	end

	always @(posedge clk) begin
		remap_result_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result index=%0d pixel=%0d",
					out_index, out_pixel));
			end else begin
				e = pending_pixels.pop_front();
				n_checked++;
				if (out_index !== e.index)
					report_mismatch($sformatf("out_index exp=%0d got=%0d",
						e.index, out_index));
				if (out_pixel !== e.pixel)
					report_mismatch($sformatf("out_pixel exp=%0d got=%0d (index %0d)",
						e.pixel, out_pixel, e.index));
			end
		end
	end

	initial begin
		logic [IDX_W-1:0] base;
		int width;
		int fx;
		int fy;
		int n_sent;
		n_loads     = 0;
		n_maps      = 0;
		n_checked   = 0;
		n_errors    = 0;
		burst_left  = 0;
		n_sent      = 0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_type    = REQ_LOAD;
		load_addr   = '0;
		load_pixel  = '0;
		src_index_a = '0;
		src_index_b = '0;
		src_index_c = '0;
		src_index_d = '0;
		weight_a    = '0;
		weight_b    = '0;
		weight_c    = '0;
		weight_d    = '0;
		dest_index  = '0;

		directed_rows.push_back(load_word('0, 8'd0));
		directed_rows.push_back(load_word(IDX_MAX, 8'd255));
		directed_rows.push_back(load_word(19'd1, 8'd128));
		directed_rows.push_back(load_word(19'd2, 8'd1));
		directed_rows.push_back(load_word(19'h2AAAA, 8'hAA));
		directed_rows.push_back(load_word(19'h55555, 8'h55));
		directed_rows.push_back(map_word(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX,
			W_ONE, '0, '0, '0, '0, 1'b1, 8'd255));
		directed_rows.push_back(map_word('0, '0, '0, '0,
			W_ONE, W_ONE, W_ONE, W_ONE, IDX_MAX, 1'b1, 8'd0));
		// saturate: four full pixels at weight one each
		directed_rows.push_back(map_word(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX,
			W_ONE, W_ONE, W_ONE, W_ONE, 19'h2AAAA, 1'b1, 8'd255));
		directed_rows.push_back(map_word(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX,
			W_FULL, W_FULL, W_FULL, W_FULL, 19'h55555, 1'b1, 8'd255));
		directed_rows.push_back(map_word(19'd1, IDX_MAX, '0, '0,
			W_ONE, '0, '0, '0, 19'd1, 1'b1, 8'd128));
		// rounding: exactly one half rounds up, just below stays down
		directed_rows.push_back(map_word(19'd2, 19'd2, 19'd2, 19'd2,
			16'd16384, '0, '0, '0, 19'd2, 1'b1, 8'd1));
		directed_rows.push_back(map_word(19'd2, 19'd2, 19'd2, 19'd2,
			16'd16383, '0, '0, '0, 19'd3, 1'b1, 8'd0));
		directed_rows.push_back(map_word(19'd1, IDX_MAX, '0, 19'd2,
			'0, '0, '0, '0, 19'd4, 1'b1, 8'd0));
		directed_rows.push_back(map_word(19'h2AAAA, 19'h55555, 19'd1, IDX_MAX,
			16'd8192, 16'd8192, 16'd8192, 16'd8192, 19'h7FFFE, 1'b0, '0));
		directed_rows.push_back(map_word(19'h55555, 19'h2AAAA, IDX_MAX, 19'd1,
			W_ONE, W_ONE, '0, '0, 19'd5, 1'b0, '0));
		directed_rows.push_back(load_word(19'd1, 8'd7));
		directed_rows.push_back(map_word(19'd2, 19'd1, 19'd2, 19'd2,
			'0, W_ONE, '0, '0, 19'd6, 1'b1, 8'd7));
		directed_rows.push_back(map_word(19'd1, 19'd2, 19'd2, 19'd2,
			W_FULL, '0, '0, '0, 19'd7, 1'b0, '0));
		directed_rows.push_back(load_word(IDX_MAX, 8'd0));
		directed_rows.push_back(map_word(IDX_MAX, 19'd2, 19'h2AAAA, 19'h55555,
			W_ONE, '0, '0, '0, 19'd8, 1'b1, 8'd0));
		directed_rows.push_back(map_word(19'h2AAAA, 19'd1, 19'd2, 19'h55555,
			16'd12345, 16'd20000, 16'd333, 16'd7777, 19'h40000, 1'b0, '0));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i]);

		while (n_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// interpolation tile: four neighbours loaded, then mapped
					case ($urandom_range(0, 3))
						0: width = 1;
						1: width = 640;
						2: width = 1024;
						default: width = $urandom_range(2, 4096);
					endcase
					base = IDX_W'($urandom_range(0, IMG_PIXELS - width - 2));
					send_word(load_word(base, PIX_W'($urandom)));
					send_word(load_word(base + 19'd1, PIX_W'($urandom)));
					send_word(load_word(base + IDX_W'(width), PIX_W'($urandom)));
					send_word(load_word(base + IDX_W'(width) + 19'd1, PIX_W'($urandom)));
					fx = $urandom_range(0, 32768);
					fy = $urandom_range(0, 32768);
					send_word(map_word(base, base + 19'd1, base + IDX_W'(width),
						base + IDX_W'(width) + 19'd1,
						WGT_W'(((32768 - fx) * (32768 - fy)) >>> 15),
						WGT_W'((fx * (32768 - fy)) >>> 15),
						WGT_W'(((32768 - fx) * fy) >>> 15),
						WGT_W'((fx * fy) >>> 15),
						IDX_W'($urandom), 1'b0, '0));
					n_sent += 5;
				end
				4, 5, 6: begin
					send_word(map_word(pick_written(), pick_written(), pick_written(),
						pick_written(), pick_weight(), pick_weight(), pick_weight(),
						pick_weight(), IDX_W'($urandom), 1'b0, '0));
					n_sent++;
				end
				7: begin
					send_word(load_word(IDX_W'($urandom_range(0, 63)), PIX_W'($urandom)));
					n_sent++;
				end
				default: begin
					send_word(load_word(IDX_W'($urandom), PIX_W'($urandom)));
					n_sent++;
				end
			endcase
		end
		req_valid = 1'b0;

		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Remap run: %0d loads and %0d map entries sent, %0d results checked.",
			n_loads, n_maps, n_checked);
		$display("Covered corner weights, rounding, saturation and random bilinear tiles.");
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
src/rmp_pkg.sv
src/rmp_front.sv
src/rmp_back.sv
src/bilinear_map_remap_top.sv
tb/sv/tb_top.sv
